// ===== sv/svp_pkg.sv =====
// Package: constants, widths and pipeline stage types for the spherical variance block.
package svp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SH        = 2 * FRAC_BITS - 16;   // extra scaling of the angle numerators
    localparam int QW        = 48;                   // quotient bits per divider
    localparam int DW        = 64;                   // divisor width
    localparam int NW        = QW + DW;              // numerator width
    localparam int DIV_LAT   = QW;                   // divider latency in cycles

    localparam logic [27:0]   KQ    = 28'd215141997; // (180/pi)^2, 16 fraction bits
    localparam logic [QW-1:0] MAX_Q = '1;

    typedef struct packed {
        logic        valid;
        logic        on_axis;
        logic [31:0] vz;
        logic [63:0] d;
        logic [63:0] p;
        logic [62:0] z2;
        logic [95:0] nr;
        logic [94:0] na;
        logic [94:0] nb;
    } t_front;

    typedef struct packed {
        logic        valid;
        logic        on_axis;
        logic [31:0] vz;
        logic [63:0] d;
        logic [63:0] p;
        logic [62:0] z2;
    } t_c1;

    typedef struct packed {
        logic        valid;
        logic        on_axis;
        logic [31:0] vz;
        logic [63:0] d;
        logic [63:0] p;
        logic [31:0] r;
        logic [63:0] z2a_lo;
        logic [62:0] z2a_hi;
        logic [63:0] pvz_lo;
        logic [63:0] pvz_hi;
        logic [60:0] kb;
    } t_p2a;

    typedef struct packed {
        logic          valid;
        logic          on_axis;
        logic [31:0]   vz;
        logic [63:0]   d;
        logic [63:0]   p;
        logic [31:0]   r;
        logic [95:0]   mnum;
        logic [NW-1:0] az_num;
        logic          az_sat;
    } t_p2b;

    typedef struct packed {
        logic        valid;
        logic        on_axis;
        logic [31:0] vz;
        logic [63:0] d;
        logic [31:0] r;
        logic        az_sat;
    } t_c2;

    typedef struct packed {
        logic          valid;
        logic          on_axis;
        logic [31:0]   vz;
        logic [63:0]   d;
        logic [31:0]   r;
        logic [QW-1:0] az;
        logic          az_sat;
        logic [59:0]   km;
    } t_p3a;

    typedef struct packed {
        logic          valid;
        logic          on_axis;
        logic [31:0]   vz;
        logic [63:0]   d;
        logic [31:0]   r;
        logic [QW-1:0] az;
        logic          az_sat;
        logic [NW-1:0] pnum;
        logic          pol_sat;
    } t_p3b;

    typedef struct packed {
        logic          valid;
        logic          on_axis;
        logic [31:0]   vz;
        logic [31:0]   r;
        logic [QW-1:0] az;
        logic          az_sat;
        logic          pol_sat;
    } t_c4;

endpackage

// ===== sv/svp_if.sv =====
// Interfaces: input item, result item and configuration write channels.
interface svp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic signed [31:0] mean_z;
    logic        [31:0] variance_x;
    logic        [31:0] variance_y;
    logic        [31:0] variance_z;

    modport source (output valid, mean_x, mean_y, mean_z, variance_x, variance_y, variance_z,
                    input ready);
    modport sink   (input valid, mean_x, mean_y, mean_z, variance_x, variance_y, variance_z,
                    output ready);
endinterface

interface svp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] variance_radius;
    logic [47:0] variance_polar_deg2;
    logic [47:0] variance_azimuth_deg2;
    logic        on_axis;
    logic        saturated;

    modport source (output valid, variance_radius, variance_polar_deg2, variance_azimuth_deg2,
                    on_axis, saturated, input ready);
    modport sink   (input valid, variance_radius, variance_polar_deg2, variance_azimuth_deg2,
                    on_axis, saturated, output ready);
endinterface

interface svp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/svp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, numerator below den * 2^QW.
module svp_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [svp_pkg::NW-1:0]  i_num,
    input  logic [svp_pkg::DW-1:0]  i_den,
    output logic [svp_pkg::QW-1:0]  o_quo
);
    import svp_pkg::*;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_nq  [QW];
    logic [DW-1:0] r_den [QW];
    logic [DW-1:0] n_rem [QW];
    logic [QW-1:0] n_nq  [QW];
    logic [DW-1:0] n_den [QW];

    always_comb begin
        logic [DW-1:0] prem;
        logic [QW-1:0] pnq;
        logic [DW-1:0] pden;
        logic [DW:0]   t;
        logic          ge;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                prem = i_num[NW-1:QW];
                pnq  = i_num[QW-1:0];
                pden = i_den;
            end else begin
                prem = r_rem[k-1];
                pnq  = r_nq[k-1];
                pden = r_den[k-1];
            end
            t        = {prem, pnq[QW-1]};
            ge       = (t >= {1'b0, pden});
            n_rem[k] = ge ? DW'(t - {1'b0, pden}) : t[DW-1:0];
            n_nq[k]  = {pnq[QW-2:0], ge};
            n_den[k] = pden;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_nq[k]  <= n_nq[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_nq[QW-1];

endmodule

// ===== sv/svp_front.sv =====
// Front end: magnitudes, axis test, squares, weighted products and numerator sums.
module svp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_mean_x,
    input  logic signed [31:0]  i_mean_y,
    input  logic signed [31:0]  i_mean_z,
    input  logic        [31:0]  i_variance_x,
    input  logic        [31:0]  i_variance_y,
    input  logic        [31:0]  i_variance_z,
    input  logic        [15:0]  i_thresh,
    output svp_pkg::t_front     o_front
);
    import svp_pkg::*;

    // product k uses square SQ_SEL[k] and variance V_SEL[k]: xvx, yvy, zvz, yvx, xvy
    localparam int SQ_SEL [5] = '{0, 1, 2, 1, 0};
    localparam int V_SEL  [5] = '{0, 1, 2, 0, 1};

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    logic        r_v1, r_on1;
    logic [31:0] r_mag [3];
    logic [31:0] r_var1 [3];

    logic        r_v2, r_on2;
    logic [62:0] r_sq [3];
    logic [31:0] r_var2 [3];

    logic        r_v3, r_on3;
    logic [63:0] r_p, r_d;
    logic [62:0] r_z2_3;
    logic [31:0] r_vz3;
    logic [63:0] r_plo [5];
    logic [62:0] r_phi [5];

    logic        r_v4, r_on4;
    logic [63:0] r_p4, r_d4;
    logic [62:0] r_z2_4;
    logic [31:0] r_vz4;
    logic [93:0] r_prod [5];

    t_front      r_front;

    logic [31:0] n_mag [3];
    logic [63:0] n_p;

    always_comb begin
        n_mag[0] = mag32(i_mean_x);
        n_mag[1] = mag32(i_mean_y);
        n_mag[2] = mag32(i_mean_z);
        n_p      = 64'(r_sq[0]) + 64'(r_sq[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_front.valid <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_front.valid <= r_v4;
        end
        if (i_en) begin
            r_on1     <= (n_mag[0] <= 32'(i_thresh)) && (n_mag[1] <= 32'(i_thresh));
            r_mag     <= n_mag;
            r_var1[0] <= i_variance_x;
            r_var1[1] <= i_variance_y;
            r_var1[2] <= i_variance_z;

            r_on2  <= r_on1;
            r_var2 <= r_var1;
            for (int k = 0; k < 3; k++) begin
                r_sq[k] <= 63'(64'(r_mag[k]) * 64'(r_mag[k]));
            end

            r_on3  <= r_on2;
            r_p    <= n_p;
            r_d    <= n_p + 64'(r_sq[2]);
            r_z2_3 <= r_sq[2];
            r_vz3  <= r_var2[2];
            for (int k = 0; k < 5; k++) begin
                r_plo[k] <= 64'(r_sq[SQ_SEL[k]][31:0]) * 64'(r_var2[V_SEL[k]]);
                r_phi[k] <= 63'(64'(r_sq[SQ_SEL[k]][62:32]) * 64'(r_var2[V_SEL[k]]));
            end

            r_on4  <= r_on3;
            r_p4   <= r_p;
            r_d4   <= r_d;
            r_z2_4 <= r_z2_3;
            r_vz4  <= r_vz3;
            for (int k = 0; k < 5; k++) begin
                r_prod[k] <= 94'(r_plo[k]) + (94'(r_phi[k]) << 32);
            end

            r_front.on_axis <= r_on4;
            r_front.vz      <= r_vz4;
            r_front.d       <= r_d4;
            r_front.p       <= r_p4;
            r_front.z2      <= r_z2_4;
            r_front.nr      <= 96'(r_prod[0]) + 96'(r_prod[1]) + 96'(r_prod[2]);
            r_front.na      <= 95'(r_prod[0]) + 95'(r_prod[1]);
            r_front.nb      <= 95'(r_prod[3]) + 95'(r_prod[4]);
        end
    end

    assign o_front = r_front;

endmodule

// ===== sv/spherical_variance_propagation.sv =====
// Top level: cartesian to spherical variance propagation pipeline.
//
//  channel  | dir | transfer carries
//  i_cfg    | in  | axis_threshold (16 bit)
//  i_in     | in  | mean_x/y/z, variance_x/y/z
//  o_out    | out | variance_radius, polar/azimuth deg^2, on_axis, saturated
//
// One item per cycle unless the output stalls: 5 front stages, three 48-stage dividers in
// series (radius/A/B, then M/azimuth, then polar) with 2 stages between, 1 output register.
// Synchronous active-low reset clears the valid bits and the threshold.
// The whole pipeline advances when the output register is empty or taken; i_in.ready
// follows that enable, so a stall holds every stage in place.
module spherical_variance_propagation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svp_cfg_if.sink     i_cfg,
    svp_in_if.sink      i_in,
    svp_out_if.source   o_out
);
    import svp_pkg::*;

    logic        en;
    logic [15:0] r_thresh;
    t_front      front;

    t_c1  r_c1 [DIV_LAT];
    t_p2a r_p2a;
    t_p2b r_p2b;
    t_c2  r_c2 [DIV_LAT];
    t_p3a r_p3a;
    t_p3b r_p3b;
    t_c4  r_c4 [DIV_LAT];

    logic [QW-1:0] q_r, q_a, q_b, q_m, q_az, q_pol;

    logic          r_out_valid;
    logic [31:0]   r_o_vr;
    logic [QW-1:0] r_o_pol, r_o_az;
    logic          r_o_on, r_o_sat;

    t_c1  n_c1;
    t_p2a n_p2a;
    t_p2b n_p2b;
    t_c2  n_c2;
    t_p3a n_p3a;
    t_p3b n_p3b;
    t_c4  n_c4;

    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg.valid) begin
            r_thresh <= i_cfg.data;
        end
    end

    svp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in.valid),
        .i_mean_x     (i_in.mean_x),
        .i_mean_y     (i_in.mean_y),
        .i_mean_z     (i_in.mean_z),
        .i_variance_x (i_in.variance_x),
        .i_variance_y (i_in.variance_y),
        .i_variance_z (i_in.variance_z),
        .i_thresh     (r_thresh),
        .o_front      (front)
    );

    // first round: radius, A, B
    svp_div u_div_r (.i_clk(i_clk), .i_en(en), .i_num(NW'(front.nr)), .i_den(front.d),
                     .o_quo(q_r));
    svp_div u_div_a (.i_clk(i_clk), .i_en(en), .i_num(NW'(front.na)), .i_den(front.p),
                     .o_quo(q_a));
    svp_div u_div_b (.i_clk(i_clk), .i_en(en), .i_num(NW'(front.nb)), .i_den(front.p),
                     .o_quo(q_b));

    // second round: M and azimuth
    svp_div u_div_m (.i_clk(i_clk), .i_en(en), .i_num(NW'(r_p2b.mnum)), .i_den(r_p2b.d),
                     .o_quo(q_m));
    svp_div u_div_az (.i_clk(i_clk), .i_en(en), .i_num(r_p2b.az_num), .i_den(r_p2b.p),
                      .o_quo(q_az));

    // third round: polar
    svp_div u_div_pol (.i_clk(i_clk), .i_en(en), .i_num(r_p3b.pnum), .i_den(r_p3b.d),
                       .o_quo(q_pol));

    always_comb begin
        logic [94:0]   z2a;
        logic [95:0]   pvz;
        logic [NW-1:0] anum;
        logic [NW-1:0] pnum;

        n_c1.valid   = front.valid;
        n_c1.on_axis = front.on_axis;
        n_c1.vz      = front.vz;
        n_c1.d       = front.d;
        n_c1.p       = front.p;
        n_c1.z2      = front.z2;

        n_p2a.valid   = r_c1[DIV_LAT-1].valid;
        n_p2a.on_axis = r_c1[DIV_LAT-1].on_axis;
        n_p2a.vz      = r_c1[DIV_LAT-1].vz;
        n_p2a.d       = r_c1[DIV_LAT-1].d;
        n_p2a.p       = r_c1[DIV_LAT-1].p;
        n_p2a.r       = q_r[31:0];
        n_p2a.z2a_lo  = 64'(r_c1[DIV_LAT-1].z2[31:0]) * 64'(q_a[31:0]);
        n_p2a.z2a_hi  = 63'(64'(r_c1[DIV_LAT-1].z2[62:32]) * 64'(q_a[31:0]));
        n_p2a.pvz_lo  = 64'(r_c1[DIV_LAT-1].p[31:0]) * 64'(r_c1[DIV_LAT-1].vz);
        n_p2a.pvz_hi  = 64'(r_c1[DIV_LAT-1].p[63:32]) * 64'(r_c1[DIV_LAT-1].vz);
        n_p2a.kb      = 61'(64'(KQ) * 64'(q_b[32:0]));

        z2a  = 95'(r_p2a.z2a_lo) + (95'(r_p2a.z2a_hi) << 32);
        pvz  = 96'(r_p2a.pvz_lo) + (96'(r_p2a.pvz_hi) << 32);
        anum = NW'(r_p2a.kb) << SH;
        n_p2b.valid   = r_p2a.valid;
        n_p2b.on_axis = r_p2a.on_axis;
        n_p2b.vz      = r_p2a.vz;
        n_p2b.d       = r_p2a.d;
        n_p2b.p       = r_p2a.p;
        n_p2b.r       = r_p2a.r;
        n_p2b.mnum    = 96'(z2a) + pvz;
        n_p2b.az_num  = anum;
        // quotient reaches 2^QW exactly when the numerator's top part reaches the divisor
        n_p2b.az_sat  = (anum >> QW) >= NW'(r_p2a.p);

        n_c2.valid   = r_p2b.valid;
        n_c2.on_axis = r_p2b.on_axis;
        n_c2.vz      = r_p2b.vz;
        n_c2.d       = r_p2b.d;
        n_c2.r       = r_p2b.r;
        n_c2.az_sat  = r_p2b.az_sat;

        n_p3a.valid   = r_c2[DIV_LAT-1].valid;
        n_p3a.on_axis = r_c2[DIV_LAT-1].on_axis;
        n_p3a.vz      = r_c2[DIV_LAT-1].vz;
        n_p3a.d       = r_c2[DIV_LAT-1].d;
        n_p3a.r       = r_c2[DIV_LAT-1].r;
        n_p3a.az_sat  = r_c2[DIV_LAT-1].az_sat;
        n_p3a.az      = r_c2[DIV_LAT-1].az_sat ? MAX_Q : q_az;
        n_p3a.km      = 60'(64'(KQ) * 64'(q_m[31:0]));

        pnum = NW'(r_p3a.km) << SH;
        n_p3b.valid   = r_p3a.valid;
        n_p3b.on_axis = r_p3a.on_axis;
        n_p3b.vz      = r_p3a.vz;
        n_p3b.d       = r_p3a.d;
        n_p3b.r       = r_p3a.r;
        n_p3b.az      = r_p3a.az;
        n_p3b.az_sat  = r_p3a.az_sat;
        n_p3b.pnum    = pnum;
        n_p3b.pol_sat = (pnum >> QW) >= NW'(r_p3a.d);

        n_c4.valid   = r_p3b.valid;
        n_c4.on_axis = r_p3b.on_axis;
        n_c4.vz      = r_p3b.vz;
        n_c4.r       = r_p3b.r;
        n_c4.az      = r_p3b.az;
        n_c4.az_sat  = r_p3b.az_sat;
        n_c4.pol_sat = r_p3b.pol_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_c1[k].valid <= 1'b0;
                r_c2[k].valid <= 1'b0;
                r_c4[k].valid <= 1'b0;
            end
            r_p2a.valid <= 1'b0;
            r_p2b.valid <= 1'b0;
            r_p3a.valid <= 1'b0;
            r_p3b.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_c1[0] <= n_c1;
            r_c2[0] <= n_c2;
            r_c4[0] <= n_c4;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_c1[k] <= r_c1[k-1];
                r_c2[k] <= r_c2[k-1];
                r_c4[k] <= r_c4[k-1];
            end
            r_p2a <= n_p2a;
            r_p2b <= n_p2b;
            r_p3a <= n_p3a;
            r_p3b <= n_p3b;
            r_out_valid <= r_c4[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_c4[DIV_LAT-1].on_axis) begin
                r_o_vr  <= r_c4[DIV_LAT-1].vz;
                r_o_pol <= '0;
                r_o_az  <= '0;
                r_o_on  <= 1'b1;
                r_o_sat <= 1'b0;
            end else begin
                r_o_vr  <= r_c4[DIV_LAT-1].r;
                r_o_pol <= r_c4[DIV_LAT-1].pol_sat ? MAX_Q : q_pol;
                r_o_az  <= r_c4[DIV_LAT-1].az;
                r_o_on  <= 1'b0;
                r_o_sat <= r_c4[DIV_LAT-1].pol_sat || r_c4[DIV_LAT-1].az_sat;
            end
        end
    end

    assign o_out.valid                 = r_out_valid;
    assign o_out.variance_radius       = r_o_vr;
    assign o_out.variance_polar_deg2   = r_o_pol;
    assign o_out.variance_azimuth_deg2 = r_o_az;
    assign o_out.on_axis               = r_o_on;
    assign o_out.saturated             = r_o_sat;

    a_on_axis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_on) |-> (r_o_pol == '0 && r_o_az == '0 && !r_o_sat))
        else $error("on-axis result with nonzero angle or saturation");

    a_sat_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_sat) |-> (r_o_pol == MAX_Q || r_o_az == MAX_Q))
        else $error("saturation flag without a clipped angle");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en) |=> ($stable(r_c4[DIV_LAT-1]) && $stable(r_p2b) && $stable(r_p3b)))
        else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/svp_tb_if.sv =====
// Testbench-side note: interfaces come from the RTL; this file holds shared result type.
`timescale 1ns / 1ps
package svp_tb_pkg;
    typedef struct {
        logic [31:0] radius;
        logic [47:0] polar;
        logic [47:0] azimuth;
        logic        on_axis;
        logic        saturated;
    } t_spherical_var;
endpackage

// ===== tb/sv/spherical_variance_propagation_tb.sv =====
// Testbench: random and directed items checked against a built-in propagation predictor.
`timescale 1ns / 1ps
module spherical_variance_propagation_tb;
    import svp_pkg::*;
    import svp_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    svp_cfg_if i_cfg ();
    svp_in_if  i_in ();
    svp_out_if o_out ();

    spherical_variance_propagation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_spherical_var expected_q[$];
    logic [15:0]    threshold;
    int             errors;
    int             idle_cycles;
    bit             calm;

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic t_spherical_var propagate(logic [31:0] mx, logic [31:0] my,
                                                 logic [31:0] mz, logic [31:0] vx,
                                                 logic [31:0] vy, logic [31:0] vz);
        t_spherical_var res;
        logic [63:0]  ax, ay, az, x2, y2, z2, p, d, a, m, b;
        logic [127:0] num, q;
        ax = mag(mx);
        ay = mag(my);
        az = mag(mz);
        res.saturated = 1'b0;
        if (ax <= threshold && ay <= threshold) begin
            res.radius = vz;
            res.polar = '0;
            res.azimuth = '0;
            res.on_axis = 1'b1;
            return res;
        end
        res.on_axis = 1'b0;
        x2 = ax * ax;
        y2 = ay * ay;
        z2 = az * az;
        p = x2 + y2;
        d = p + z2;
        num = 128'(x2) * vx + 128'(y2) * vy + 128'(z2) * vz;
        q = num / d;
        res.radius = q[31:0];
        q = (128'(x2) * vx + 128'(y2) * vy) / p;
        a = q[63:0];
        q = (128'(z2) * a + 128'(p) * vz) / d;
        m = q[63:0];
        q = (128'(y2) * vx + 128'(x2) * vy) / p;
        b = q[63:0];
        num = 128'(64'(64'(KQ) * m)) << SH;
        q = num / d;
        if (q > 128'(MAX_Q)) begin
            res.polar = MAX_Q;
            res.saturated = 1'b1;
        end else begin
            res.polar = q[47:0];
        end
        num = 128'(64'(64'(KQ) * b)) << SH;
        q = num / p;
        if (q > 128'(MAX_Q)) begin
            res.azimuth = MAX_Q;
            res.saturated = 1'b1;
        end else begin
            res.azimuth = q[47:0];
        end
        return res;
    endfunction

    task automatic random_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
    endtask

    // valid stays high after a transfer so items can follow back to back
    task automatic send_item(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        random_gap();
        i_in.valid <= 1'b1;
        i_in.mean_x <= mx;
        i_in.mean_y <= my;
        i_in.mean_z <= mz;
        i_in.variance_x <= vx;
        i_in.variance_y <= vy;
        i_in.variance_z <= vz;
        do @(posedge i_clk); while (!i_in.ready);
        expected_q.push_back(propagate(mx, my, mz, vx, vy, vz));
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        i_in.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg.valid <= 1'b1;
        i_cfg.data <= value;
        do @(posedge i_clk); while (!i_cfg.ready);
        threshold = value;
        @(negedge i_clk);
        i_cfg.valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [31:0] ext[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1,
                                32'hFFFF_FFFF, 32'h0001_0000};
        write_threshold(16'd0);
        foreach (ext[i]) send_item(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6],
                                   32'hFFFF_FFFF, 32'h0, 32'h0001_0000);
        send_item(32'h0, 32'h0, 32'h0001_0000, 32'h5, 32'h6, 32'h7);
        send_item(32'h1, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        send_item(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1,
                  32'hFFFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_threshold(16'hFFFF);
        send_item(32'h0000_FFFF, 32'hFFFF_0001, 32'h3, 32'h1, 32'h2, 32'h1234_5678);
        send_item(32'h0001_0000, 32'h0, 32'h3, 32'h1, 32'h2, 32'h3);
        send_item(32'hFFFF_0000, 32'h10, 32'h3, 32'h1, 32'h2, 32'h3);
    endtask

    function automatic logic [31:0] rand_coord(logic [15:0] thr);
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * thr + 2)) - $signed({16'h0, thr}) - 1);
            2: return $urandom_range(0, 32'h000F_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
            3: return {$urandom_range(0, 1) == 1 ? 8'hFF : 8'h00, 24'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic test_random(logic [15:0] thr, int count);
        write_threshold(thr);
        repeat (count) begin
            send_item(rand_coord(thr), rand_coord(thr), rand_coord(thr),
                      $urandom, $urandom >> $urandom_range(0, 31), $urandom);
        end
    endtask

    task automatic test_steady(int count);
        calm = 1'b1;
        repeat (count) send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // result checker and output-side stalls
    initial begin
        t_spherical_var exp_r;
        o_out.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out.valid && o_out.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result radius=%h", $time, o_out.variance_radius);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_out.variance_radius !== exp_r.radius ||
                        o_out.variance_polar_deg2 !== exp_r.polar ||
                        o_out.variance_azimuth_deg2 !== exp_r.azimuth ||
                        o_out.on_axis !== exp_r.on_axis ||
                        o_out.saturated !== exp_r.saturated) begin
                        $display("%0t mismatch expected r=%h pol=%h az=%h ax=%b sat=%b",
                                 $time, exp_r.radius, exp_r.polar, exp_r.azimuth,
                                 exp_r.on_axis, exp_r.saturated);
                        $display("%0t          actual   r=%h pol=%h az=%h ax=%b sat=%b",
                                 $time, o_out.variance_radius, o_out.variance_polar_deg2,
                                 o_out.variance_azimuth_deg2, o_out.on_axis,
                                 o_out.saturated);
                        errors++;
                    end
                end
            end
            @(negedge i_clk);
            if (calm || $urandom_range(0, 5) != 0) begin
                o_out.ready <= 1'b1;
            end else begin
                o_out.ready <= 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in.valid && i_in.ready) || (o_out.valid && o_out.ready) ||
            (i_cfg.valid && i_cfg.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        calm = 1'b0;
        threshold = '0;
        i_in.valid = 1'b0;
        i_in.mean_x = '0;
        i_in.mean_y = '0;
        i_in.mean_z = '0;
        i_in.variance_x = '0;
        i_in.variance_y = '0;
        i_in.variance_z = '0;
        i_cfg.valid = 1'b0;
        i_cfg.data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(16'd0, 400);
        test_random(16'hFFFF, 300);
        test_random(16'($urandom), 400);
        test_random(16'd40, 250);
        test_steady(200);
        i_in.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
